[rtl/wmrp_pkg.sv]
// Shared types and constants for the min/max/RMS overview pyramid.
package wmrp_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 4;
   localparam int LENGTH_W = 26;
   localparam int RMS_W    = 16;
   localparam int BASE_W   = 11;
   localparam int LCNT_W   = 5;
   localparam int SQ_W     = 2 * SAMPLE_W - 1;
   localparam int RAD_W    = 2 * RMS_W;

   // Configuration register indexes
   localparam logic CSR_BASE_FRAMES = 1'b0;
   localparam logic CSR_LEVEL_COUNT = 1'b1;

   localparam logic [BASE_W-1:0] BASE_RESET = 11'd256;
   localparam logic [LCNT_W-1:0] LCNT_RESET = 5'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_DIV,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_OUT_LOAD,
      ST_OUT_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic out_load;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic emit_hit;
      logic at_top;
      logic eos;
   } status_type;

endpackage

[rtl/waveform_min_max_rms_pyramid_core.sv]
// Top level of the min/max/RMS overview pyramid.
// Each accepted sample transaction updates every active level in turn, one level per
// cycle, then scans the levels in order, one per cycle while no bucket closes, and each
// level whose bucket closes produces one result in ascending level order. A closing
// bucket adds a restoring division of its sum of squares by its length (one quotient
// bit per cycle), loading of the square-root radicand, a digit-by-digit square root and
// a load of the result register; the result is then held until taken. Input is taken
// only while the block is idle, so a new sample is not accepted before the previous
// one is finished. A configuration write restarts the stream.
module waveform_min_max_rms_pyramid_core #(
   parameter int MAX_LEVELS      = 16,
   parameter int MAX_BASE_FRAMES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // sample[15:0]
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // level[3:0], minimum, maximum, rms, length, zero pad
   output logic         rsp_tlast,   // last_of_run
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [10:0]  csr_wdata
);
   import wmrp_pkg::*;

   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int FILL_W = $clog2(MAX_BASE_FRAMES) + MAX_LEVELS;
   localparam int SUM_W  = FILL_W + 2 * SAMPLE_W - 2;

   cmd_type cmd;
   status_type status;
   logic [LVL_W-1:0] lvl;
   logic [LEVEL_W-1:0] out_level;
   logic signed [SAMPLE_W-1:0] out_min;
   logic signed [SAMPLE_W-1:0] out_max;
   logic [RMS_W-1:0] out_rms;
   logic [LENGTH_W-1:0] out_length;

   wmrp_control #(
      .LVL_W (LVL_W),
      .SUM_W (SUM_W)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .lvl        (lvl)
   );

   wmrp_datapath #(
      .MAX_LEVELS      (MAX_LEVELS),
      .MAX_BASE_FRAMES (MAX_BASE_FRAMES),
      .LVL_W           (LVL_W),
      .FILL_W          (FILL_W),
      .SUM_W           (SUM_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .lvl        (lvl),
      .status     (status),
      .in_sample  (req_tdata),
      .in_eos     (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .out_level  (out_level),
      .out_min    (out_min),
      .out_max    (out_max),
      .out_rms    (out_rms),
      .out_length (out_length),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_length, out_rms, out_max, out_min, out_level};

endmodule

[rtl/wmrp_datapath.sv]
// Datapath: per-level bucket state, divider, square root and result register.
module wmrp_datapath #(
   parameter int MAX_LEVELS      = 16,
   parameter int MAX_BASE_FRAMES = 1024,
   parameter int LVL_W           = 4,
   parameter int FILL_W          = 26,
   parameter int SUM_W           = 56
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wmrp_pkg::cmd_type                     cmd,
   input  logic [LVL_W-1:0]                      lvl,
   output wmrp_pkg::status_type                  status,
   input  logic signed [wmrp_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic                                  in_eos,
   input  logic                                  csr_we,
   input  logic                                  csr_addr,
   input  logic [wmrp_pkg::BASE_W-1:0]           csr_wdata,
   output logic [wmrp_pkg::LEVEL_W-1:0]          out_level,
   output logic signed [wmrp_pkg::SAMPLE_W-1:0]  out_min,
   output logic signed [wmrp_pkg::SAMPLE_W-1:0]  out_max,
   output logic [wmrp_pkg::RMS_W-1:0]            out_rms,
   output logic [wmrp_pkg::LENGTH_W-1:0]         out_length,
   output logic                                  out_last
);
   import wmrp_pkg::*;

   localparam int CMPW  = 18;
   localparam int REM_W = FILL_W + 1;
   localparam int SREM_W = RMS_W + 2;

   logic [BASE_W-1:0] base_ff;
   logic [LCNT_W-1:0] lcnt_ff;
   logic signed [SAMPLE_W-1:0] samp_ff;
   logic eos_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [MAX_LEVELS-1:0] mask_ff;

   logic [FILL_W-1:0] fill_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] full_ff;
   logic signed [SAMPLE_W-1:0] min_ff [MAX_LEVELS];
   logic signed [SAMPLE_W-1:0] max_ff [MAX_LEVELS];
   logic [SUM_W-1:0] sum_ff [MAX_LEVELS];

   logic [REM_W-1:0] rem_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [FILL_W-1:0] divisor_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [RMS_W-1:0] root_ff;

   // Effective configuration
   logic [FILL_W-1:0] base_eff;
   logic [LVL_W-1:0] top_lvl;
   logic [CMPW-1:0] base_x;
   logic [CMPW-1:0] lcnt_x;
   always_comb begin
      base_x = CMPW'(base_ff);
      lcnt_x = CMPW'(lcnt_ff);
      if (base_x == '0) begin
         base_eff = FILL_W'(1);
      end else if (base_x > CMPW'(MAX_BASE_FRAMES)) begin
         base_eff = FILL_W'(MAX_BASE_FRAMES);
      end else begin
         base_eff = FILL_W'(base_ff);
      end
      if (lcnt_x == '0) begin
         top_lvl = '0;
      end else if (lcnt_x > CMPW'(MAX_LEVELS)) begin
         top_lvl = LVL_W'(MAX_LEVELS - 1);
      end else begin
         top_lvl = LVL_W'(lcnt_x - CMPW'(1));
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         lcnt_ff <= LCNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BASE_FRAMES: base_ff <= csr_wdata;
            CSR_LEVEL_COUNT: lcnt_ff <= csr_wdata[LCNT_W-1:0];
            default:         base_ff <= base_ff;
         endcase
      end
   end

   // Input capture; square registered before accumulation
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff <= in_sample;
         eos_ff  <= in_eos;
         sq_ff   <= SQ_W'(in_sample * in_sample);
      end
   end

   // Bucket update for the selected level
   logic [FILL_W-1:0] fill_old;
   logic [FILL_W-1:0] fill_new;
   logic [FILL_W-1:0] size_lvl;
   logic first;
   logic full_hit;
   logic emit_now;
   logic signed [SAMPLE_W-1:0] min_new;
   logic signed [SAMPLE_W-1:0] max_new;
   logic [SUM_W-1:0] sum_new;
   always_comb begin
      fill_old = fill_ff[lvl];
      first    = (fill_old == '0);
      fill_new = fill_old + FILL_W'(1);
      size_lvl = base_eff << lvl;
      full_hit = (fill_new >= size_lvl);
      emit_now = full_hit || (eos_ff && ((lvl == '0) || full_ff[lvl]));
      min_new  = (first || samp_ff < min_ff[lvl]) ? samp_ff : min_ff[lvl];
      max_new  = (first || samp_ff > max_ff[lvl]) ? samp_ff : max_ff[lvl];
      sum_new  = (first ? '0 : sum_ff[lvl]) + SUM_W'(sq_ff);
   end

   // Fill counts and full marks, cleared on reset, config write or stream end
   always_ff @(posedge clock) begin
      if (reset || csr_we || cmd.clear_all) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            fill_ff[i] <= '0;
         end
         full_ff <= '0;
      end else if (cmd.update) begin
         fill_ff[lvl] <= fill_new;
         if (full_hit) begin
            full_ff[lvl] <= 1'b1;
         end
      end else if (cmd.out_load) begin
         fill_ff[lvl] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         min_ff[lvl] <= min_new;
         max_ff[lvl] <= max_new;
         sum_ff[lvl] <= sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         mask_ff <= '0;
      end else if (cmd.update) begin
         mask_ff[lvl] <= emit_now;
      end
   end

   // Restoring divider: one quotient bit per step
   logic [REM_W:0] rem_sh;
   logic rem_ge;
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      rem_ge = (rem_sh >= (REM_W+1)'(divisor_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff     <= '0;
         quo_ff     <= sum_ff[lvl];
         divisor_ff <= fill_ff[lvl];
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? REM_W'(rem_sh - (REM_W+1)'(divisor_ff)) : REM_W'(rem_sh);
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
      end
   end

   // Digit-by-digit square root: one result bit per step
   logic [SREM_W+1:0] srem_sh;
   logic [SREM_W+1:0] trial;
   logic sq_ge;
   always_comb begin
      srem_sh = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      sq_ge   = (srem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         rad_ff  <= RAD_W'(quo_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sq_ge ? SREM_W'(srem_sh - trial) : SREM_W'(srem_sh);
         root_ff <= {root_ff[RMS_W-2:0], sq_ge};
      end
   end

   // Last result of this transaction: no emitting level above the current one
   logic is_last;
   always_comb begin
      is_last = 1'b1;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if ((LVL_W'(i) > lvl) && mask_ff[i]) begin
            is_last = 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_level  <= LEVEL_W'(lvl);
         out_min    <= min_ff[lvl];
         out_max    <= max_ff[lvl];
         out_rms    <= root_ff;
         out_length <= LENGTH_W'(fill_ff[lvl]);
         out_last   <= is_last;
      end
   end

   assign status.emit_hit = mask_ff[lvl];
   assign status.at_top   = (lvl == top_lvl);
   assign status.eos      = eos_ff;

endmodule

[rtl/wmrp_control.sv]
// Controller: sequences level updates, division, square root and result handoff.
module wmrp_control #(
   parameter int LVL_W = 4,
   parameter int SUM_W = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  wmrp_pkg::status_type  status,
   output wmrp_pkg::cmd_type     cmd,
   output logic [LVL_W-1:0]      lvl
);
   import wmrp_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   state_type state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [CNT_W-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         iter_ff  <= iter_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            lvl_in = '0;
            if (req_tvalid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (status.at_top) begin
               lvl_in   = '0;
               state_in = ST_SCAN;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         ST_SCAN: begin
            iter_in = '0;
            if (status.emit_hit) begin
               state_in = ST_DIV;
            end else if (status.at_top) begin
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         ST_DIV: begin
            iter_in = iter_ff + CNT_W'(1);
            if (iter_ff == CNT_W'(SUM_W - 1)) begin
               state_in = ST_SQRT_LOAD;
            end
         end
         ST_SQRT_LOAD: begin
            iter_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            iter_in = iter_ff + CNT_W'(1);
            if (iter_ff == CNT_W'(RMS_W - 1)) begin
               state_in = ST_OUT_LOAD;
            end
         end
         ST_OUT_LOAD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               if (status.at_top) begin
                  state_in = ST_DONE;
               end else begin
                  lvl_in   = lvl_ff + LVL_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_UPDATE:    cmd.update = 1'b1;
         ST_SCAN:      cmd.div_load = status.emit_hit;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
         ST_SQRT:      cmd.sqrt_step = 1'b1;
         ST_OUT_LOAD:  cmd.out_load = 1'b1;
         ST_OUT_WAIT:  rsp_tvalid = 1'b1;
         ST_DONE:      cmd.clear_all = status.eos;
         default:      cmd = '0;
      endcase
   end

   assign lvl = lvl_ff;

endmodule
